// File: rtl/core/ils_pkg.sv
// Package for the indexed list store.
// Holds sizes, command codes and status codes used by the top level.
// No dependencies.
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_APPEND    = 3'd0;
    localparam t_cmd CMD_INSERT    = 3'd1;
    localparam t_cmd CMD_OVERWRITE = 3'd2;
    localparam t_cmd CMD_DELETE    = 3'd3;
    localparam t_cmd CMD_DUMP      = 3'd4;
    localparam t_cmd CMD_CLEAR     = 3'd5;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_BADIDX = 2'd2;
    localparam t_status ST_EMPTY  = 2'd3;

endpackage

// File: rtl/core/ils_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/indexed_list_store_top.sv
// Indexed list store top level: command decode, shift sequencer and output register.
// Depends on ils_pkg and ils_ram.
//
// Ordered list of up to CAPACITY signed 32-bit words kept in one RAM with a registered
// read. Append, overwrite, clear, unknown commands and every rejected command move no
// entries. Insert at index p moves entries p to n - 1 up by one and delete moves entries
// after p down by one: one RAM read and one write-back per moved entry, set by the single
// write port. Dump gives one item per cycle while the output side is ready. A new item is
// taken only once the previous one has been placed in the output register.
module indexed_list_store_top
    import ils_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [WORD_W-1:0] i_word_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [WORD_W-1:0] o_word_out,
    output logic [POS_W-1:0]         o_where,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DUMP,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic              r_gone, n_gone;
    logic              r_dv, n_dv;
    logic [POS_W-1:0]  r_didx, n_didx;

    t_status           r_res_status, n_res_status;
    logic [WORD_W-1:0] r_res_word, n_res_word;
    logic [POS_W-1:0]  r_res_where, n_res_where;
    logic [CNT_W-1:0]  r_res_count, n_res_count;

    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_word_out, n_word_out;
    logic [POS_W-1:0]  r_where, n_where;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_last, n_last;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic              in_acc, out_free, full;
    logic [CNT_W-1:0]  idx_dec, fill_inc, fill_dec, pos_ext, in_pos_ext, didx_inc;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign full       = r_fill >= CNT_W'(CAPACITY);
    assign idx_dec    = r_idx - CNT_W'(1);
    assign fill_inc   = r_fill + CNT_W'(1);
    assign fill_dec   = r_fill - CNT_W'(1);
    assign pos_ext    = {1'b0, r_pos};
    assign in_pos_ext = {1'b0, i_position};
    assign didx_inc   = {1'b0, r_didx} + CNT_W'(1);

    ils_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_word       = r_word;
        n_wv         = r_wv;
        n_waddr      = r_waddr;
        n_gone       = r_gone;
        n_dv         = r_dv;
        n_didx       = r_didx;
        n_res_status = r_res_status;
        n_res_word   = r_res_word;
        n_res_where  = r_res_where;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_word_out   = r_word_out;
        n_where      = r_where;
        n_count      = r_count;
        n_last       = r_last;
        ram_we       = 1'b0;
        ram_waddr    = r_waddr;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_word   = '0;
                    n_res_where  = '0;
                    n_res_count  = r_fill;
                    n_state      = S_EMIT;
                    case (i_command)
                        CMD_APPEND: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = r_fill[ADDR_W-1:0];
                                ram_wdata   = i_word_in;
                                n_fill      = fill_inc;
                                n_res_where = r_fill[POS_W-1:0];
                                n_res_count = fill_inc;
                            end
                        end
                        CMD_INSERT: begin
                            n_res_where = i_position;
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else if (in_pos_ext > r_fill) begin
                                n_res_status = ST_BADIDX;
                            end else begin
                                n_idx   = r_fill;
                                n_pos   = i_position;
                                n_word  = i_word_in;
                                n_wv    = 1'b0;
                                n_state = S_INS;
                            end
                        end
                        CMD_OVERWRITE: begin
                            n_res_where = i_position;
                            if (in_pos_ext >= r_fill) begin
                                n_res_status = ST_BADIDX;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = i_position[ADDR_W-1:0];
                                ram_wdata = i_word_in;
                            end
                        end
                        CMD_DELETE: begin
                            n_res_where = i_position;
                            if (in_pos_ext >= r_fill) begin
                                n_res_status = ST_BADIDX;
                            end else begin
                                n_idx   = in_pos_ext;
                                n_pos   = i_position;
                                n_wv    = 1'b0;
                                n_gone  = 1'b0;
                                n_state = S_DEL;
                            end
                        end
                        CMD_DUMP: begin
                            if (r_fill == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_dv      = 1'b1;
                                n_didx    = '0;
                                n_idx     = CNT_W'(1);
                                n_state   = S_DUMP;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill      = '0;
                            n_res_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_wv) begin
                    ram_we = 1'b1;
                    n_wv   = 1'b0;
                end else if (r_idx == pos_ext) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_pos[ADDR_W-1:0];
                    ram_wdata    = r_word;
                    n_fill       = fill_inc;
                    n_res_status = ST_OK;
                    n_res_where  = r_pos;
                    n_res_count  = fill_inc;
                    n_state      = S_EMIT;
                end
                if (r_idx > pos_ext) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[ADDR_W-1:0];
                    n_wv      = 1'b1;
                    n_waddr   = r_idx[ADDR_W-1:0];
                    n_idx     = idx_dec;
                end
            end
            S_DEL: begin
                if (r_wv) begin
                    ram_we = 1'b1;
                    n_wv   = 1'b0;
                end
                if (r_gone) begin
                    n_res_word = ram_rdata;
                    n_gone     = 1'b0;
                end
                if (r_idx < r_fill) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    if (r_idx == pos_ext) begin
                        n_gone = 1'b1;
                    end else begin
                        n_wv    = 1'b1;
                        n_waddr = idx_dec[ADDR_W-1:0];
                    end
                end else if (!r_wv && !r_gone) begin
                    n_fill       = fill_dec;
                    n_res_status = ST_OK;
                    n_res_where  = r_pos;
                    n_res_count  = fill_dec;
                    n_state      = S_EMIT;
                end
            end
            S_DUMP: begin
                if (r_dv && out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_word_out  = ram_rdata;
                    n_where     = r_didx;
                    n_count     = r_fill;
                    n_last      = (didx_inc == r_fill);
                    if (r_idx < r_fill) begin
                        ram_re = 1'b1;
                        n_didx = r_idx[POS_W-1:0];
                        n_idx  = r_idx + CNT_W'(1);
                    end else begin
                        n_dv    = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_word_out  = r_res_word;
                    n_where     = r_res_where;
                    n_count     = r_res_count;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wv        <= 1'b0;
            r_gone      <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wv        <= n_wv;
            r_gone      <= n_gone;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_word       <= n_word;
        r_waddr      <= n_waddr;
        r_didx       <= n_didx;
        r_res_status <= n_res_status;
        r_res_word   <= n_res_word;
        r_res_where  <= n_res_where;
        r_res_count  <= n_res_count;
        r_status     <= n_status;
        r_word_out   <= n_word_out;
        r_where      <= n_where;
        r_count      <= n_count;
        r_last       <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_word_out  = r_word_out;
    assign o_where     = r_where;
    assign o_count     = r_count;
    assign o_last      = r_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_CLEAR) |=> (r_fill == '0))
        else $error("clear left entries");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !in_acc) |-> !ram_we)
        else $error("RAM write while idle");

    a_dump_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && r_dv) |-> ({1'b0, r_didx} < r_fill))
        else $error("dump index past fill");

endmodule
